>>> hw/rtl/kvd_pkg.sv
// Shared types and constants for the key/value message deframer.
// No dependencies; imported by kvd_core and key_value_message_deframer_top.
package kvd_pkg;

    localparam int LengthBits = 32;

    localparam logic [15:0] VersionReset = 16'd1;

    typedef enum logic [2:0] {
        PH_VER_HI = 3'd0,
        PH_VER_LO = 3'd1,
        PH_KEYLEN = 3'd2,
        PH_KEY    = 3'd3,
        PH_VALLEN = 3'd4,
        PH_VAL    = 3'd5,
        PH_DONE   = 3'd6
    } t_phase;

    typedef enum logic [2:0] {
        ROLE_VERSION = 3'd0,
        ROLE_LENGTH  = 3'd1,
        ROLE_KEY     = 3'd2,
        ROLE_VALUE   = 3'd3,
        ROLE_IGNORED = 3'd4
    } t_role;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_VERSION = 2'd1,
        ST_TRUNC   = 2'd2,
        ST_PADDING = 2'd3
    } t_status;

    typedef struct packed {
        logic [7:0] data;
        t_role      role;
        logic       key_end;
        logic       value_end;
        logic       message_end;
        t_status    status;
    } t_result;

endpackage

>>> hw/rtl/kvd_core.sv
// Parser state and per-byte classification logic for the deframer.
// Depends on kvd_pkg for phase, role, status and result types.
module kvd_core (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_step,
    input  logic [7:0]      i_byte,
    input  logic            i_fin,
    input  logic [15:0]     i_version,
    output kvd_pkg::t_result o_result
);
    import kvd_pkg::*;

    t_phase                r_phase, n_phase;
    logic [1:0]            r_idx, n_idx;
    logic [LengthBits-1:0] r_acc, n_acc;
    logic [LengthBits-1:0] r_rem, n_rem;
    logic [7:0]            r_ver_hi, n_ver_hi;
    t_status               r_err, n_err;

    logic [LengthBits+7:0] len_shift;
    logic [LengthBits-1:0] len_next;
    logic [LengthBits-1:0] rem_dec;
    logic                  len_last;
    logic                  clean;
    t_role                 role;
    logic                  kend, vend;
    t_status               verdict;

    // Shift in one length byte; saturate a length that overflows the field.
    assign len_shift = {r_acc, i_byte};
    assign len_next  = (|len_shift[LengthBits+7:LengthBits]) ? '1
                                                              : len_shift[LengthBits-1:0];
    assign rem_dec   = r_rem - LengthBits'(1);
    assign len_last  = (r_idx == 2'd3);

    always_comb begin
        n_phase  = r_phase;
        n_idx    = r_idx;
        n_acc    = r_acc;
        n_rem    = r_rem;
        n_ver_hi = r_ver_hi;
        n_err    = r_err;
        role     = ROLE_IGNORED;
        kend     = 1'b0;
        vend     = 1'b0;
        clean    = 1'b0;
        if (r_err == ST_OK) begin
            unique case (r_phase)
                PH_VER_HI: begin
                    role     = ROLE_VERSION;
                    n_ver_hi = i_byte;
                    n_phase  = PH_VER_LO;
                end
                PH_VER_LO: begin
                    role = ROLE_VERSION;
                    if ({r_ver_hi, i_byte} != i_version) begin
                        n_err = ST_VERSION;
                    end
                    n_phase = PH_KEYLEN;
                    n_idx   = 2'd0;
                    n_acc   = '0;
                end
                PH_KEYLEN: begin
                    role  = ROLE_LENGTH;
                    n_acc = len_next;
                    n_idx = r_idx + 2'd1;
                    if (len_last) begin
                        if (len_next == '0) begin
                            n_phase = PH_DONE;
                            clean   = 1'b1;
                        end else begin
                            n_rem   = len_next;
                            n_phase = PH_KEY;
                        end
                        n_acc = '0;
                    end
                end
                PH_KEY: begin
                    role  = ROLE_KEY;
                    n_rem = rem_dec;
                    if (rem_dec == '0) begin
                        kend    = 1'b1;
                        n_phase = PH_VALLEN;
                        n_idx   = 2'd0;
                        n_acc   = '0;
                    end
                end
                PH_VALLEN: begin
                    role  = ROLE_LENGTH;
                    n_acc = len_next;
                    n_idx = r_idx + 2'd1;
                    if (len_last) begin
                        if (len_next == '0) begin
                            vend    = 1'b1;
                            n_phase = PH_KEYLEN;
                        end else begin
                            n_rem   = len_next;
                            n_phase = PH_VAL;
                        end
                        n_acc = '0;
                    end
                end
                PH_VAL: begin
                    role  = ROLE_VALUE;
                    n_rem = rem_dec;
                    if (rem_dec == '0) begin
                        vend    = 1'b1;
                        n_phase = PH_KEYLEN;
                        n_idx   = 2'd0;
                        n_acc   = '0;
                    end
                end
                default: begin
                    // Anything after the end marker is padding.
                    role  = ROLE_IGNORED;
                    n_err = ST_PADDING;
                end
            endcase
        end
    end

    always_comb begin
        if (i_fin && n_err == ST_OK) begin
            verdict = clean ? ST_OK : ST_TRUNC;
        end else begin
            verdict = n_err;
        end
    end

    always_comb begin
        o_result.data        = i_byte;
        o_result.role        = role;
        o_result.key_end     = kend;
        o_result.value_end   = vend;
        o_result.message_end = i_fin;
        o_result.status      = verdict;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_step && i_fin)) begin
            r_phase  <= PH_VER_HI;
            r_idx    <= 2'd0;
            r_acc    <= '0;
            r_rem    <= '0;
            r_ver_hi <= 8'd0;
            r_err    <= ST_OK;
        end else if (i_step) begin
            r_phase  <= n_phase;
            r_idx    <= n_idx;
            r_acc    <= n_acc;
            r_rem    <= n_rem;
            r_ver_hi <= n_ver_hi;
            r_err    <= n_err;
        end
    end

endmodule

>>> hw/rtl/key_value_message_deframer_top.sv
// Key/value message deframer: top level with input and result registers.
// Depends on kvd_pkg and kvd_core.
//
// Usage:
//   Input channel (i_in_valid / o_in_ready) carries one message byte per beat
//   plus a flag on the last byte of the buffer. Result channel
//   (o_out_valid / i_out_ready) returns one beat per input beat: the byte,
//   its role, key and pair end marks, the final flag and a status.
//   Each accepted beat passes through the input register and then the result
//   register, where its result is presented; a stalled receiver can hold it
//   in between. Throughput: one beat per cycle while the receiver does not
//   stall, set by the parser step between the two registers.
//   A stalled receiver holds the result register; the input register still
//   takes one more beat, then o_in_ready drops until the result drains.
//   The final byte delivers the message verdict and returns the parser to
//   its start state. The user must write the accepted version register
//   (i_cfg_we / i_cfg_wdata, no wait) only while the block is idle; it
//   does not enforce this itself. Reset (i_rst_n low, synchronous) empties
//   both registers, clears the parser and sets the accepted version to 1.
module key_value_message_deframer_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_final_byte,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [7:0]  o_data_out,
    output logic [2:0]  o_byte_role,
    output logic        o_key_end,
    output logic        o_value_end,
    output logic        o_message_end,
    output logic [1:0]  o_status
);
    import kvd_pkg::*;

    logic [15:0] r_version;
    logic        r_in_vld;
    logic [7:0]  r_in_byte;
    logic        r_in_fin;
    logic        r_out_vld;
    t_result     r_out;
    t_result     step_result;
    logic        advance;

    // Advance the input beat into the result register when that slot frees.
    assign advance    = r_in_vld && (!r_out_vld || i_out_ready);
    assign o_in_ready = !r_in_vld || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_version <= VersionReset;
        end else if (i_cfg_we) begin
            r_version <= i_cfg_wdata;
        end
    end

    // Input register: hold the beat until the parser consumes it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (o_in_ready) begin
            r_in_vld <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_byte <= i_data_byte;
            r_in_fin  <= i_final_byte;
        end
    end

    kvd_core u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_step    (advance),
        .i_byte    (r_in_byte),
        .i_fin     (r_in_fin),
        .i_version (r_version),
        .o_result  (step_result)
    );

    // Result register: drop the beat once taken, load the next one.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (advance) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= step_result;
        end
    end

    assign o_out_valid   = r_out_vld;
    assign o_data_out    = r_out.data;
    assign o_byte_role   = r_out.role;
    assign o_key_end     = r_out.key_end;
    assign o_value_end   = r_out.value_end;
    assign o_message_end = r_out.message_end;
    assign o_status      = r_out.status;

`ifndef NO_ASSERTIONS
    // An ignored byte only follows an error or the end marker.
    a_ignored_has_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_out.role == ROLE_IGNORED) |-> (r_out.status != ST_OK))
        else $error("ignored byte reported with ok status");

    a_key_end_role: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_out.key_end) |-> (r_out.role == ROLE_KEY))
        else $error("key end on a non-key byte");

    a_value_end_role: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_out.value_end) |->
        (r_out.role == ROLE_VALUE || r_out.role == ROLE_LENGTH))
        else $error("pair end on a byte that is neither value nor length");

    a_stall_holds_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> (r_in_vld && r_out_vld && !i_out_ready))
        else $error("input stalled without a full pipeline");
`endif

endmodule
